// ===== design/hbcr_pkg.sv =====
`timescale 1ns / 1ps
// hbcr_pkg: types, band codes, register indexes and target colors for the
// humidity band color ramp. No dependencies.
package hbcr_pkg;

    localparam int HUM_BITS   = 10;
    localparam int STALE_BITS = 16;
    localparam int BLINK_BITS = 8;
    localparam int CH_BITS    = 8;
    localparam int BAND_BITS  = 2;
    localparam int IDX_BITS   = 3;
    localparam int DATA_BITS  = 16;

    localparam logic [BAND_BITS-1:0] BAND_DRY     = 2'd0;
    localparam logic [BAND_BITS-1:0] BAND_OPTIMAL = 2'd1;
    localparam logic [BAND_BITS-1:0] BAND_DAMP    = 2'd2;
    localparam logic [BAND_BITS-1:0] BAND_ERROR   = 2'd3;

    localparam logic [IDX_BITS-1:0] REG_DRY_THRESHOLD  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_DAMP_THRESHOLD = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_HYSTERESIS     = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_STALE_TICKS    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BLINK_TICKS    = 3'd4;

    localparam logic [HUM_BITS-1:0]   DRY_THRESHOLD_RST  = 10'd400;
    localparam logic [HUM_BITS-1:0]   DAMP_THRESHOLD_RST = 10'd700;
    localparam logic [HUM_BITS-1:0]   HYSTERESIS_RST     = 10'd20;
    localparam logic [STALE_BITS-1:0] STALE_TICKS_RST    = 16'd250;
    localparam logic [BLINK_BITS-1:0] BLINK_TICKS_RST    = 8'd25;

    localparam logic [CH_BITS-1:0] CH_FULL = 8'd255;
    localparam logic [CH_BITS-1:0] CH_OFF  = 8'd0;

    typedef struct packed {
        logic [HUM_BITS-1:0]   dry_threshold;
        logic [HUM_BITS-1:0]   damp_threshold;
        logic [HUM_BITS-1:0]   hysteresis;
        logic [STALE_BITS-1:0] stale_ticks;
        logic [BLINK_BITS-1:0] blink_ticks;
    } hbcr_cfg_t;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } hbcr_rgb_t;

    typedef struct packed {
        logic [BAND_BITS-1:0]  band_state;
        hbcr_rgb_t             ramp;
        logic                  blink_on;
        logic [BLINK_BITS-1:0] blink_count;
    } hbcr_state_t;

    typedef struct packed {
        hbcr_rgb_t            rgb;
        logic [BAND_BITS-1:0] band;
    } hbcr_pixel_t;

    function automatic hbcr_rgb_t target_color(input logic [BAND_BITS-1:0] band);
        hbcr_rgb_t t;
        unique case (band)
            BAND_DRY:     t = '{red: 8'd255, green: 8'd120, blue: 8'd0};
            BAND_OPTIMAL: t = '{red: 8'd0,   green: 8'd255, blue: 8'd100};
            BAND_DAMP:    t = '{red: 8'd0,   green: 8'd50,  blue: 8'd255};
            default:      t = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return t;
    endfunction

    function automatic logic [CH_BITS-1:0] step_toward(input logic [CH_BITS-1:0] cur,
                                                       input logic [CH_BITS-1:0] target);
        logic [CH_BITS-1:0] r;
        if (cur < target)
            r = cur + 1'b1;
        else if (cur > target)
            r = cur - 1'b1;
        else
            r = cur;
        return r;
    endfunction

endpackage

// ===== design/hbcr_next.sv =====
`timescale 1ns / 1ps
// hbcr_next: per-tick next-state logic: sample age, band hysteresis,
// color ramp and error blink. Depends on hbcr_pkg.
module hbcr_next #(
    parameter int AGE_BITS = 16
) (
    input  hbcr_pkg::hbcr_cfg_t              cfg,
    input  hbcr_pkg::hbcr_state_t            st,
    input  logic [AGE_BITS-1:0]              age,
    input  logic [hbcr_pkg::HUM_BITS-1:0]    humidity,
    input  logic                             sample_fresh,
    output hbcr_pkg::hbcr_state_t            st_next,
    output logic [AGE_BITS-1:0]              age_next,
    output hbcr_pkg::hbcr_pixel_t            pixel
);
    import hbcr_pkg::*;

    localparam int CMP_BITS = (AGE_BITS > STALE_BITS) ? AGE_BITS : STALE_BITS;

    logic [CMP_BITS-1:0]   age_ext;
    logic [CMP_BITS-1:0]   stale_ext;
    logic [HUM_BITS:0]     hum_plus_hyst;
    logic [BAND_BITS-1:0]  band_next;
    hbcr_rgb_t             target;
    logic [BLINK_BITS-1:0] blink_inc;

    always_comb
    begin
        if (sample_fresh)
            age_next = '0;
        else if (age != {AGE_BITS{1'b1}})
            age_next = age + 1'b1;
        else
            age_next = age;
    end

    assign age_ext       = CMP_BITS'(age_next);
    assign stale_ext     = CMP_BITS'(cfg.stale_ticks);
    // one bit wider so the hysteresis sum never wraps
    assign hum_plus_hyst = {1'b0, humidity} + {1'b0, cfg.hysteresis};

    always_comb
    begin
        band_next = st.band_state;
        if (age_ext > stale_ext)
        begin
            band_next = BAND_ERROR;
        end
        else
        begin
            unique case (st.band_state)
                BAND_DRY:
                begin
                    if (humidity >= cfg.dry_threshold)
                        band_next = BAND_OPTIMAL;
                end
                BAND_OPTIMAL:
                begin
                    priority if (hum_plus_hyst < {1'b0, cfg.dry_threshold})
                        band_next = BAND_DRY;
                    else if (humidity >= cfg.damp_threshold)
                        band_next = BAND_DAMP;
                    else
                        band_next = BAND_OPTIMAL;
                end
                BAND_DAMP:
                begin
                    if (hum_plus_hyst < {1'b0, cfg.damp_threshold})
                        band_next = BAND_OPTIMAL;
                end
                default:
                    band_next = BAND_OPTIMAL;
            endcase
        end
    end

    assign target    = target_color(band_next);
    assign blink_inc = st.blink_count + 1'b1;

    always_comb
    begin
        st_next            = st;
        st_next.band_state = band_next;
        if (band_next != BAND_ERROR)
        begin
            st_next.ramp.red   = step_toward(st.ramp.red, target.red);
            st_next.ramp.green = step_toward(st.ramp.green, target.green);
            st_next.ramp.blue  = step_toward(st.ramp.blue, target.blue);
            pixel.rgb          = st_next.ramp;
        end
        else
        begin
            if (blink_inc >= cfg.blink_ticks)
            begin
                st_next.blink_on    = ~st.blink_on;
                st_next.blink_count = '0;
            end
            else
            begin
                st_next.blink_count = blink_inc;
            end
            // ramp restarts from black once the error clears
            st_next.ramp    = '0;
            pixel.rgb.red   = st_next.blink_on ? CH_FULL : CH_OFF;
            pixel.rgb.green = CH_OFF;
            pixel.rgb.blue  = CH_OFF;
        end
        pixel.band = band_next;
    end

endmodule

// ===== design/humidity_band_color_ramp_top.sv =====
`timescale 1ns / 1ps
// humidity_band_color_ramp_top: top level with config registers, tick state
// and the result register. Depends on hbcr_pkg and hbcr_next.
//
// Usage:
//   in channel   (in_valid/in_ready): one transfer per 20 ms tick carrying
//                humidity (tenths of a percent) and sample_fresh.
//   out channel  (out_valid/out_ready): one pixel color and band per tick.
//   cfg channel  (cfg_valid/cfg_ready): register index and write data;
//                cfg_ready is always high, unknown indexes are dropped.
//                Write only while no tick is in flight.
// Latency: the result for a tick is presented the cycle after its transfer.
// Throughput: one tick per cycle when not stalled; tick state and result
//   register update in the transfer cycle by a single combinational pass.
// Stall: while a result waits and out_ready is low the result register holds
//   its value and in_ready drops; it rises in the cycle the result is taken.
// Reset: thresholds return to 400/700, hysteresis 20, stale limit 250,
//   blink period 25; band is optimal, ramp black, blink off, age zero,
//   no result pending.
module humidity_band_color_ramp_top #(
    parameter int AGE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hbcr_pkg::HUM_BITS-1:0]       humidity,
    input  logic                                sample_fresh,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hbcr_pkg::CH_BITS-1:0]        red,
    output logic [hbcr_pkg::CH_BITS-1:0]        green,
    output logic [hbcr_pkg::CH_BITS-1:0]        blue,
    output logic [hbcr_pkg::BAND_BITS-1:0]      band,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hbcr_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [hbcr_pkg::DATA_BITS-1:0]      cfg_data
);
    import hbcr_pkg::*;

    hbcr_cfg_t           cfg_reg;
    hbcr_state_t         st_reg;
    hbcr_state_t         st_next;
    logic [AGE_BITS-1:0] age_reg;
    logic [AGE_BITS-1:0] age_next;
    hbcr_pixel_t         pixel_reg;
    hbcr_pixel_t         pixel_next;
    logic                out_valid_reg;
    logic                in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_xfer   = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dry_threshold  <= DRY_THRESHOLD_RST;
            cfg_reg.damp_threshold <= DAMP_THRESHOLD_RST;
            cfg_reg.hysteresis     <= HYSTERESIS_RST;
            cfg_reg.stale_ticks    <= STALE_TICKS_RST;
            cfg_reg.blink_ticks    <= BLINK_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DRY_THRESHOLD:  cfg_reg.dry_threshold  <= cfg_data[HUM_BITS-1:0];
                REG_DAMP_THRESHOLD: cfg_reg.damp_threshold <= cfg_data[HUM_BITS-1:0];
                REG_HYSTERESIS:     cfg_reg.hysteresis     <= cfg_data[HUM_BITS-1:0];
                REG_STALE_TICKS:    cfg_reg.stale_ticks    <= cfg_data[STALE_BITS-1:0];
                REG_BLINK_TICKS:    cfg_reg.blink_ticks    <= cfg_data[BLINK_BITS-1:0];
                default:            ;
            endcase
        end
    end

    hbcr_next #(
        .AGE_BITS (AGE_BITS)
    ) u_next (
        .cfg          (cfg_reg),
        .st           (st_reg),
        .age          (age_reg),
        .humidity     (humidity),
        .sample_fresh (sample_fresh),
        .st_next      (st_next),
        .age_next     (age_next),
        .pixel        (pixel_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.band_state  <= BAND_OPTIMAL;
            st_reg.ramp        <= '0;
            st_reg.blink_on    <= 1'b0;
            st_reg.blink_count <= '0;
            age_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                st_reg  <= st_next;
                age_reg <= age_next;
            end
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            pixel_reg <= pixel_next;
    end

    assign out_valid = out_valid_reg;
    assign red       = pixel_reg.rgb.red;
    assign green     = pixel_reg.rgb.green;
    assign blue      = pixel_reg.rgb.blue;
    assign band      = pixel_reg.band;

endmodule

// ===== design/hbcr_checker.sv =====
`timescale 1ns / 1ps
// hbcr_checker: port-level assertions for the humidity band color ramp,
// bound to humidity_band_color_ramp_top. Depends on hbcr_pkg.
module hbcr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [hbcr_pkg::CH_BITS-1:0]    red,
    input logic [hbcr_pkg::CH_BITS-1:0]    green,
    input logic [hbcr_pkg::CH_BITS-1:0]    blue,
    input logic [hbcr_pkg::BAND_BITS-1:0]  band
);
    import hbcr_pkg::*;

    // a pending result that is not taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({red, green, blue, band}))
        else $error("result changed or dropped while stalled");

    // empty result register always takes a tick
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no result pending");

    // a stalled result blocks new ticks
    a_block_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("tick taken over a stalled result");

    // error band shows only red blink or black
    a_error_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && band == BAND_ERROR |->
            green == CH_OFF && blue == CH_OFF && (red == CH_OFF || red == CH_FULL))
        else $error("bad color in error band");

endmodule

bind humidity_band_color_ramp_top hbcr_checker u_hbcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .band      (band)
);
